// ===== rtl/core/procedural_tile_texel_generator_unit_assert.svh =====
// Assertion macros for the procedural tile texel generator.
// Included by the top-level module, which carries concurrent checks; no other dependencies.
`ifndef PROCEDURAL_TILE_TEXEL_GENERATOR_UNIT_ASSERT_SVH
`define PROCEDURAL_TILE_TEXEL_GENERATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define PTTG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PTTG_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTTG_ASSERT(lbl, clk, rstn, prop, msg)
`define PTTG_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/pttg_pkg.sv =====
// Shared types, constants and preset table for the procedural tile texel generator.
// No dependencies.
package pttg_pkg;

  localparam int unsigned MaxTileSize = 256;

  localparam logic [31:0] HashA = 32'd374761393;
  localparam logic [31:0] HashB = 32'd668265263;
  localparam logic [31:0] HashS = 32'd1274126177;
  localparam logic [31:0] HashCell = 32'd1640531527;

  localparam logic [1:0] PatStone = 2'd0;
  localparam logic [1:0] PatChecker = 2'd1;
  localparam logic [1:0] PatWood = 2'd2;
  localparam logic [1:0] PatMarble = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] param;
    logic [23:0] c0;
    logic [23:0] c1;
  } preset_t;

  // Hash request to the shared hash unit.
  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] s;
  } hash_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] h;
  } hash_rsp_t;

  function automatic preset_t preset(input logic [3:0] idx);
    preset_t p;
    p = '0;
    case (idx)
      4'd0:  p = '{PatStone, 8'd42, {8'd140, 8'd130, 8'd120}, 24'd0};
      4'd1:  p = '{PatChecker, 8'd8, {8'd180, 8'd140, 8'd100}, {8'd160, 8'd120, 8'd80}};
      4'd2:  p = '{PatStone, 8'd99, {8'd60, 8'd60, 8'd65}, 24'd0};
      4'd3:  p = '{PatChecker, 8'd4, {8'd255, 8'd255, 8'd0}, {8'd200, 8'd200, 8'd0}};
      4'd4:  p = '{PatStone, 8'd17, {8'd180, 8'd60, 8'd50}, 24'd0};
      4'd5:  p = '{PatStone, 8'd33, {8'd60, 8'd100, 8'd180}, 24'd0};
      4'd6:  p = '{PatStone, 8'd55, {8'd80, 8'd160, 8'd70}, 24'd0};
      4'd7:  p = '{PatMarble, 8'd42, {8'd200, 8'd200, 8'd195}, 24'd0};
      4'd8:  p = '{PatWood, 8'd77, {8'd100, 8'd60, 8'd40}, 24'd0};
      4'd9:  p = '{PatStone, 8'd31, {8'd110, 8'd105, 8'd100}, 24'd0};
      4'd10: p = '{PatStone, 8'd58, {8'd180, 8'd170, 8'd130}, 24'd0};
      4'd11: p = '{PatStone, 8'd63, {8'd120, 8'd60, 8'd160}, 24'd0};
      4'd12: p = '{PatChecker, 8'd8, {8'd200, 8'd120, 8'd70}, {8'd170, 8'd100, 8'd55}};
      4'd13: p = '{PatChecker, 8'd16, {8'd50, 8'd160, 8'd150}, {8'd35, 8'd130, 8'd120}};
      4'd14: p = '{PatMarble, 8'd88, {8'd180, 8'd120, 8'd150}, 24'd0};
      4'd15: p = '{PatStone, 8'd101, {8'd30, 8'd35, 8'd50}, 24'd0};
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [10:0] v);
    logic [7:0] r;
    if (v < 0) r = 8'd0;
    else if (v > 11'sd255) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction

  // c * 3 / 4
  function automatic logic [7:0] scale34(input logic [7:0] c);
    logic [9:0] t;
    t = {2'b0, c} + {1'b0, c, 1'b0};
    return t[9:2];
  endfunction

  // c * 2 / 3, c * 2 below 512
  function automatic logic [7:0] scale23(input logic [7:0] c);
    logic [8:0] t;
    logic [19:0] m;
    t = {c, 1'b0};
    m = 20'(t) * 20'd683;
    return m[18:11];
  endfunction

endpackage

// ===== rtl/core/procedural_tile_texel_generator_unit.sv =====
// Procedural tile texel generator top level: config port, sequencer and output register.
// Depends on pttg_pkg, pttg_hash and procedural_tile_texel_generator_unit_assert.svh.
// Out-of-range and checker items use no hash; stone and wood items take one hash, and marble
// items take 112 hashes plus ten remainders by tile_size.
// A new item is taken in the cycle after its result is registered; out_stall_i holds the result.
// Reset clears control state; tile_size resets to 32 and seed_shift to 0.
`include "procedural_tile_texel_generator_unit_assert.svh"
module procedural_tile_texel_generator_unit #(
  parameter int unsigned MAX_TILE_SIZE = pttg_pkg::MaxTileSize
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [9:0] cell_index_i,
  input  logic [7:0] pos_x_i,
  input  logic [7:0] pos_y_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic       in_range_o
);
  localparam int TsW = $clog2(MAX_TILE_SIZE + 1);

  typedef enum logic [3:0] {
    SIdle, SSetup, SNoise1, SNoise2, SShade, SVeinLx, SVeinLy, SVeinJ, SVeinHit,
    SOut
  } state_e;

  // Configuration registers.
  logic [8:0] tile_size_q;
  logic [7:0] seed_shift_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_size_q <= 9'd32;
      seed_shift_q <= 8'd0;
    end else if (wr_en) begin
      if (paddr[2] == 1'b0) tile_size_q <= pwdata[8:0];
      else seed_shift_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == 1'b0) prdata[8:0] = tile_size_q;
    else prdata[7:0] = seed_shift_q;
  end

  // Effective tile size, saturated into 1..MAX_TILE_SIZE.
  logic [TsW-1:0] ts;
  always_comb begin
    if (tile_size_q == 9'd0) ts = TsW'(1);
    else if (32'(tile_size_q) > MAX_TILE_SIZE) ts = TsW'(MAX_TILE_SIZE);
    else ts = TsW'(tile_size_q);
  end

  // Item registers and sequencer state.
  state_e      state_q;
  logic [9:0]  unused_pad_q;
  logic [7:0]  x_q, y_q;
  logic [1:0]  kind_q;
  logic [7:0]  cellsz_q;
  logic [31:0] seed_q;
  logic [23:0] base_q, alt_q;
  logic [7:0]  n1_q;
  logic [2:0]  vi_q;
  logic [4:0]  vj_q;
  logic [TsW-1:0] lx_q, ystep_q, py_q;
  logic [7:0]  r_q, g_q, b_q;
  logic        inr_q;
  logic        busy_hash_q;
  logic [7:0]  rem_q;

  // Restoring remainder of an 8-bit hash by ts, one bit per cycle.
  logic [3:0] rbit_q;
  logic [8:0] rrem_q;
  logic       rdo_q;

  pttg_pkg::hash_req_t hreq;
  pttg_pkg::hash_rsp_t hrsp;

  pttg_hash u_hash (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (hreq),
    .rsp_o (hrsp)
  );

  // Input decode at acceptance.
  pttg_pkg::preset_t pr;
  logic [31:0] hcell;
  logic [20:0] c3prod;
  logic [9:0]  c3q, c3rem;
  logic [1:0]  cmod3;
  logic [23:0] pbase;
  logic        accept;
  assign pr = pttg_pkg::preset(cell_index_i[3:0]);
  assign hcell = 32'(cell_index_i) * pttg_pkg::HashCell;
  // Index mod 3 through a reciprocal multiply; exact for all 10-bit indexes.
  assign c3prod = 21'(cell_index_i) * 21'd683;
  assign c3q = {1'b0, c3prod[19:11]};
  assign c3rem = cell_index_i - (c3q + {c3q[8:0], 1'b0});
  assign cmod3 = c3rem[1:0];
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != SIdle);

  always_comb begin
    pbase = hcell[23:0];
    if (seed_shift_q != 8'd0) begin
      pbase[23:16] = hcell[23:16] + 8'd80;
      pbase[15:8] = hcell[15:8] + 8'd40;
      pbase[7:0] = hcell[7:0] + 8'd120;
    end
  end

  // Hash requests by state. No request goes out while a remainder is being worked.
  always_comb begin
    hreq = '0;
    hreq.start = (state_q == SNoise1 || state_q == SNoise2 || state_q == SVeinLx ||
                  state_q == SVeinLy || state_q == SVeinJ) && !busy_hash_q && !rdo_q;
    case (state_q)
      SNoise1: begin
        if (kind_q == pttg_pkg::PatWood) begin
          hreq.a = 32'({x_q, 1'b0});
          hreq.b = 32'(y_q) * 32'd5;
        end else begin
          hreq.a = 32'(x_q);
          hreq.b = 32'(y_q);
        end
        hreq.s = seed_q;
      end
      SNoise2: begin
        hreq.a = 32'(x_q) + 32'd50;
        hreq.b = 32'(y_q) + 32'd50;
        hreq.s = seed_q + 32'd1;
      end
      SVeinLx: begin hreq.a = 32'(vi_q); hreq.b = seed_q; hreq.s = 32'd0; end
      SVeinLy: begin hreq.a = 32'(vi_q); hreq.b = seed_q; hreq.s = 32'd1; end
      SVeinJ:  begin hreq.a = 32'(vj_q); hreq.b = 32'(vi_q); hreq.s = seed_q; end
      default: hreq = '0;
    endcase
  end

  // Shading arithmetic for noise patterns. The divide by 3 truncates toward zero,
  // so it works on the magnitude and puts the sign back afterwards.
  logic signed [10:0] v;
  logic [8:0]  nsum;
  logic signed [9:0] nc;
  logic [7:0]  nmag;
  logic [15:0] q3prod;
  logic signed [10:0] q3s;
  logic [7:0]  sr, sg, sb;
  always_comb begin
    nsum = 9'(n1_q) + 9'(hrsp.h);
    case (kind_q)
      pttg_pkg::PatStone, pttg_pkg::PatWood: begin
        nc = $signed({2'b0, n1_q}) - 10'sd128;
      end
      default: begin
        nc = $signed({2'b0, nsum[8:1]}) - 10'sd128;
      end
    endcase
    nmag = nc[9] ? 8'(-nc) : nc[7:0];
    q3prod = 16'(nmag) * 16'd171;
    q3s = $signed({4'b0, q3prod[15:9]});
    case (kind_q)
      pttg_pkg::PatStone: v = 11'(nc / 4);
      default: v = nc[9] ? -q3s : q3s;
    endcase
    sr = pttg_pkg::clamp8($signed({3'b0, base_q[23:16]}) + v);
    sg = pttg_pkg::clamp8($signed({3'b0, base_q[15:8]}) + v);
    sb = pttg_pkg::clamp8($signed({3'b0, base_q[7:0]}) + v);
  end

  // Row mod 3 for the wood grain, through a reciprocal multiply.
  logic [15:0] y3prod;
  logic [7:0]  y3q, y3rem;
  assign y3prod = 16'(y_q) * 16'd171;
  assign y3q = {1'b0, y3prod[15:9]};
  assign y3rem = y_q - (y3q + {y3q[6:0], 1'b0});

  // Vein point position. The hash mod 5 also comes from a reciprocal multiply.
  logic [15:0] m5prod;
  logic [7:0]  m5q;
  logic [7:0]  m5;
  logic signed [TsW+2:0] px;
  logic       vein_hit;
  assign m5prod = 16'(hrsp.h) * 16'd205;
  assign m5q = {2'b0, m5prod[15:10]};
  assign m5 = hrsp.h - ({m5q[5:0], 2'b0} + m5q);
  assign px = $signed({3'b0, lx_q}) + $signed((TsW+3)'(m5)) - $signed((TsW+3)'(2));
  assign vein_hit = (px >= 0) && (px < $signed({3'b0, ts})) &&
                    (py_q < ts) && (px == $signed({3'b0, x_q})) &&
                    (py_q == TsW'(y_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      busy_hash_q <= 1'b0;
      out_valid_o <= 1'b0;
      rdo_q <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i && state_q != SOut) out_valid_o <= 1'b0;
      if (hreq.start) busy_hash_q <= 1'b1;
      if (hrsp.done) busy_hash_q <= 1'b0;
      case (state_q)
        SIdle: if (accept) begin
          x_q <= pos_x_i;
          y_q <= pos_y_i;
          state_q <= SSetup;
          inr_q <= (TsW'(pos_x_i) < ts) && (TsW'(pos_y_i) < ts);
          if (cell_index_i < 10'd16) begin
            kind_q <= pr.kind;
            cellsz_q <= pr.param;
            seed_q <= 32'(pr.param) + 32'(seed_shift_q);
            base_q <= pr.c0;
            alt_q <= pr.c1;
          end else begin
            base_q <= pbase;
            alt_q <= {1'b0, pbase[23:17], 1'b0, pbase[15:9], 1'b0, pbase[7:1]};
            cellsz_q <= 8'd8;
            case (cmod3)
              2'd0: begin
                kind_q <= pttg_pkg::PatStone;
                seed_q <= 32'(cell_index_i) * 32'd37 + 32'(seed_shift_q);
              end
              2'd1: begin
                kind_q <= pttg_pkg::PatChecker;
                seed_q <= '0;
              end
              default: begin
                kind_q <= pttg_pkg::PatMarble;
                seed_q <= 32'(cell_index_i) * 32'd73 + 32'(seed_shift_q);
              end
            endcase
          end
        end
        SSetup: begin
          // ts / 20 through a reciprocal multiply; exact for ts below 512.
          ystep_q <= TsW'((32'(ts) * 32'd205) >> 12);
          if (!inr_q) begin
            {r_q, g_q, b_q} <= '0;
            state_q <= SOut;
          end else if (kind_q == pttg_pkg::PatChecker) begin
            // Cell sizes are 4, 8 or 16, so the divides are shifts.
            case (cellsz_q)
              8'd4: {r_q, g_q, b_q} <= (x_q[2] ^ y_q[2]) ? alt_q : base_q;
              8'd16: {r_q, g_q, b_q} <= (x_q[4] ^ y_q[4]) ? alt_q : base_q;
              default: {r_q, g_q, b_q} <= (x_q[3] ^ y_q[3]) ? alt_q : base_q;
            endcase
            state_q <= SOut;
          end else begin
            state_q <= SNoise1;
          end
        end
        SNoise1: if (hrsp.done) begin
          n1_q <= hrsp.h;
          state_q <= (kind_q == pttg_pkg::PatMarble) ? SNoise2 : SShade;
        end
        SNoise2: if (hrsp.done) begin
          {r_q, g_q, b_q} <= {sr, sg, sb};
          vi_q <= '0;
          state_q <= SVeinLx;
        end
        SShade: begin
          if (kind_q == pttg_pkg::PatWood) begin
            if (y3rem == 8'd0)
              {r_q, g_q, b_q} <= {pttg_pkg::scale34(sr), pttg_pkg::scale34(sg),
                                  pttg_pkg::scale34(sb)};
            else {r_q, g_q, b_q} <= {sr, sg, sb};
          end else begin
            case ({y_q[3:0] == 4'd0, x_q[3:0] == 4'd0})
              2'b11: {r_q, g_q, b_q} <= {pttg_pkg::scale34(pttg_pkg::scale34(sr)),
                                         pttg_pkg::scale34(pttg_pkg::scale34(sg)),
                                         pttg_pkg::scale34(pttg_pkg::scale34(sb))};
              2'b10, 2'b01: {r_q, g_q, b_q} <= {pttg_pkg::scale34(sr),
                                                pttg_pkg::scale34(sg),
                                                pttg_pkg::scale34(sb)};
              default: {r_q, g_q, b_q} <= {sr, sg, sb};
            endcase
          end
          state_q <= SOut;
        end
        SVeinLx, SVeinLy: begin
          if (hrsp.done && !rdo_q) begin
            rdo_q <= 1'b1;
            rrem_q <= '0;
            rem_q <= hrsp.h;
            rbit_q <= 4'd8;
          end else if (rdo_q) begin
            if (rbit_q == 4'd0) begin
              rdo_q <= 1'b0;
              if (state_q == SVeinLx) begin
                lx_q <= TsW'(rrem_q);
                state_q <= SVeinLy;
              end else begin
                py_q <= TsW'(rrem_q);
                vj_q <= '0;
                state_q <= SVeinJ;
              end
            end else begin
              if ({rrem_q[7:0], rem_q[7]} >= 9'(ts))
                rrem_q <= {rrem_q[7:0], rem_q[7]} - 9'(ts);
              else rrem_q <= {rrem_q[7:0], rem_q[7]};
              rem_q <= {rem_q[6:0], 1'b0};
              rbit_q <= rbit_q - 4'd1;
            end
          end
        end
        SVeinJ: if (hrsp.done) begin
          if (vein_hit)
            {r_q, g_q, b_q} <= {pttg_pkg::scale23(r_q), pttg_pkg::scale23(g_q),
                                pttg_pkg::scale23(b_q)};
          py_q <= py_q + ystep_q;
          if (vj_q == 5'd19) begin
            if (vi_q == 3'd4) state_q <= SOut;
            else begin
              vi_q <= vi_q + 3'd1;
              state_q <= SVeinLx;
            end
          end else vj_q <= vj_q + 5'd1;
        end
        SOut: begin
          if (!out_valid_o || !out_stall_i) begin
            red_o <= r_q;
            green_o <= g_q;
            blue_o <= b_q;
            in_range_o <= inr_q;
            out_valid_o <= 1'b1;
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  `PTTG_ASSERT(a_busy_stall, clk_i, rst_ni, (state_q != SIdle) |-> in_stall_o, "busy but ready")
  `PTTG_ASSERT(a_black, clk_i, rst_ni, (out_valid_o && !in_range_o) |-> ({red_o, green_o, blue_o} == 24'd0), "out of range not black")
  `PTTG_ASSERT(a_accept_busy, clk_i, rst_ni, accept |=> (state_q == SSetup), "accept lost")
endmodule

// ===== rtl/core/pttg_hash.sv =====
// Shared multi-cycle hash unit: one 32x32 multiply per cycle in its multiply states, through one multiplier.
// Depends on pttg_pkg.
module pttg_hash (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pttg_pkg::hash_req_t req_i,
  output pttg_pkg::hash_rsp_t rsp_o
);
  typedef enum logic [2:0] {HIdle, HMa, HMb, HMs, HMix, HDone} hstate_e;

  hstate_e     state_q;
  logic [31:0] acc_q, b_q, s_q;
  logic [31:0] mul_a, mul_b, prod;

  always_comb begin
    mul_a = acc_q;
    mul_b = pttg_pkg::HashA;
    case (state_q)
      HMa:  begin mul_a = acc_q; mul_b = pttg_pkg::HashA; end
      HMb:  begin mul_a = b_q;   mul_b = pttg_pkg::HashB; end
      HMs:  begin mul_a = s_q;   mul_b = pttg_pkg::HashS; end
      HMix: begin mul_a = acc_q ^ (acc_q >> 13); mul_b = pttg_pkg::HashS; end
      default: begin mul_a = acc_q; mul_b = pttg_pkg::HashA; end
    endcase
    prod = mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HIdle;
      acc_q <= '0;
      b_q <= '0;
      s_q <= '0;
    end else begin
      case (state_q)
        HIdle: if (req_i.start) begin
          acc_q <= req_i.a;
          b_q <= req_i.b;
          s_q <= req_i.s;
          state_q <= HMa;
        end
        HMa: begin b_q <= b_q; s_q <= s_q; acc_q <= prod; state_q <= HMb; end
        HMb: begin b_q <= prod; state_q <= HMs; end
        HMs: begin acc_q <= acc_q + b_q + prod; state_q <= HMix; end
        HMix: begin acc_q <= prod ^ (prod >> 16); state_q <= HDone; end
        HDone: state_q <= HIdle;
        default: state_q <= HIdle;
      endcase
    end
  end

  assign rsp_o.done = (state_q == HDone);
  assign rsp_o.h = acc_q[7:0];
endmodule
